[sv/rqer_pkg.sv]
// Shared types, constants and the root table for the read quality error rate block.
`timescale 1ns / 1ps
`default_nettype none

package rqer_pkg;

  // Fixed-point format of the reported error rate.
  localparam int unsigned ERR_FRAC_BITS = 24;
  localparam int unsigned ERR_W = ERR_FRAC_BITS + 1;

  // Phred+33 offset and log2(10)/10 in Q.32.
  localparam logic [7:0]  PHRED_OFFSET = 8'd33;
  localparam logic [31:0] LOG2_10_Q32  = 32'd1426757253;

  // Counter limits and the reset value of reads_wanted.
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] READS_WANTED_RST = 32'd10000;

  // One input item.
  typedef struct packed {
    logic       action;
    logic       seq_present;
    logic       qual_present;
    logic [7:0] qual_char;
    logic       end_of_read;
  } rqer_in_t;

  // One result item.
  typedef struct packed {
    logic [24:0] error_rate;
    logic [39:0] bases_counted;
    logic [31:0] unscored_reads;
    logic [15:0] longest_read;
    logic [31:0] scored_reads;
  } rqer_out_t;

  // Accumulated statistics as seen by the sequencer.
  typedef struct packed {
    logic [47:0] quality_sum;
    logic [39:0] base_count;
    logic [31:0] unscored;
    logic [15:0] longest;
    logic [31:0] scored;
  } stats_t;

  // Divider status.
  typedef struct packed {
    logic        done;
    logic        zero;
    logic [31:0] mean;
  } div_status_t;

  // Exponent unit status.
  typedef struct packed {
    logic              done;
    logic [ERR_W-1:0]  err;
  } exp_status_t;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXP,
    ST_LOAD
  } seq_state_t;

  // Exponent unit phases.
  typedef enum logic [1:0] {
    EX_IDLE,
    EX_TMUL,
    EX_ROOT,
    EX_ROUND
  } exp_phase_t;

  // Table of repeated square roots of one half, Q.32.
  typedef logic [31:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] res;
    logic [63:0] bv;
    xr  = x;
    res = 64'd0;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (xr >= res + bv) begin
        xr  = xr - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] a;
    a = 64'h0000_0000_8000_0000;
    for (int k = 0; k < 32; k++) begin
      a = isqrt64(a << 32);
      tab[k] = a[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

[sv/rqer_stats.sv]
// Per-position statistics accumulator with the reads_wanted register.
`timescale 1ns / 1ps
`default_nettype none

module rqer_stats #(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire rqer_pkg::rqer_in_t item,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  output rqer_pkg::stats_t       stats
);
  import rqer_pkg::*;

  localparam int unsigned CW = (LEN_BITS > 16) ? LEN_BITS : 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  logic [31:0]         reads_wanted_r, reads_wanted_nxt;
  logic [LEN_BITS-1:0] cur_len_r, cur_len_nxt;
  logic                cur_qual_r, cur_qual_nxt;
  logic [31:0]         info_r, info_nxt;
  logic [31:0]         unsc_r, unsc_nxt;
  logic [39:0]         base_r, base_nxt;
  logic [47:0]         qsum_r, qsum_nxt;
  logic [15:0]         maxlen_r, maxlen_nxt;

  logic [LEN_BITS-1:0] len_step;
  logic [7:0]          q_val;
  logic [48:0]         qsum_add;
  logic [CW-1:0]       len_ext;
  logic [15:0]         len_clip;
  logic                qual_after;

  // Arithmetic on the current position.
  always_comb begin
    len_step   = (item.seq_present && (cur_len_r != LEN_MAX)) ? cur_len_r + 1'b1 : cur_len_r;
    q_val      = (item.qual_char >= PHRED_OFFSET) ? item.qual_char - PHRED_OFFSET : 8'd0;
    qsum_add   = {1'b0, qsum_r} + {41'd0, q_val};
    len_ext    = CW'(len_step);
    len_clip   = (len_ext > CW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
    qual_after = cur_qual_r | item.qual_present;
  end

  // Next state of all counters.
  always_comb begin
    reads_wanted_nxt = reads_wanted_r;
    cur_len_nxt      = cur_len_r;
    cur_qual_nxt     = cur_qual_r;
    info_nxt         = info_r;
    unsc_nxt         = unsc_r;
    base_nxt         = base_r;
    qsum_nxt         = qsum_r;
    maxlen_nxt       = maxlen_r;
    if (cfg_we) begin
      reads_wanted_nxt = cfg_wdata;
    end
    if (item_valid) begin
      if (item.action) begin
        // Finish clears everything but the longest read and reads_wanted.
        cur_len_nxt  = '0;
        cur_qual_nxt = 1'b0;
        info_nxt     = '0;
        unsc_nxt     = '0;
        base_nxt     = '0;
        qsum_nxt     = '0;
      end else if (info_r >= reads_wanted_r) begin
        // Enough reads taken: only the read boundary is tracked.
        if (item.end_of_read) begin
          cur_len_nxt  = '0;
          cur_qual_nxt = 1'b0;
        end
      end else begin
        cur_len_nxt = len_step;
        if (item.qual_present) begin
          cur_qual_nxt = 1'b1;
          qsum_nxt     = qsum_add[48] ? MAX48 : qsum_add[47:0];
          base_nxt     = (base_r != MAX40) ? base_r + 40'd1 : MAX40;
        end
        if (item.end_of_read) begin
          if (len_clip > maxlen_r) begin
            maxlen_nxt = len_clip;
          end
          if (qual_after) begin
            info_nxt = (info_r != MAX32) ? info_r + 32'd1 : MAX32;
          end else begin
            unsc_nxt = (unsc_r != MAX32) ? unsc_r + 32'd1 : MAX32;
          end
          cur_len_nxt  = '0;
          cur_qual_nxt = 1'b0;
        end
      end
    end
  end

  // Counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reads_wanted_r <= READS_WANTED_RST;
      cur_len_r      <= '0;
      cur_qual_r     <= 1'b0;
      info_r         <= '0;
      unsc_r         <= '0;
      base_r         <= '0;
      qsum_r         <= '0;
      maxlen_r       <= '0;
    end else begin
      reads_wanted_r <= reads_wanted_nxt;
      cur_len_r      <= cur_len_nxt;
      cur_qual_r     <= cur_qual_nxt;
      info_r         <= info_nxt;
      unsc_r         <= unsc_nxt;
      base_r         <= base_nxt;
      qsum_r         <= qsum_nxt;
      maxlen_r       <= maxlen_nxt;
    end
  end

  assign stats.quality_sum = qsum_r;
  assign stats.base_count  = base_r;
  assign stats.unscored    = unsc_r;
  assign stats.longest     = maxlen_r;
  assign stats.scored      = info_r;

endmodule

`default_nettype wire

[sv/rqer_div.sv]
// Restoring divider that forms the mean quality in Q.24, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rqer_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [47:0]     sum,
  input  wire logic [39:0]     cnt,
  output rqer_pkg::div_status_t status
);
  import rqer_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] q_r, q_nxt;
  logic [39:0] n_r, n_nxt;
  logic        zero_r, zero_nxt;

  logic [40:0] trial;
  logic [40:0] diff;
  logic        ge;

  // Shared compare and subtract.
  always_comb begin
    trial = {rem_r, low_r[31]};
    diff  = trial - {1'b0, n_r};
    ge    = trial >= {1'b0, n_r};
  end

  // Step control and datapath update.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    n_nxt    = n_r;
    zero_nxt = zero_r;
    if (start) begin
      // The quotient fits in 32 bits exactly when the mean is below 256.
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {sum[47:8]};
      low_nxt  = {sum[7:0], 24'd0};
      q_nxt    = '0;
      n_nxt    = cnt;
      zero_nxt = (cnt == 40'd0) || (sum >= {cnt, 8'd0});
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[39:0] : trial[39:0];
      low_nxt  = {low_r[30:0], 1'b0};
      q_nxt    = {q_r[30:0], ge};
      step_nxt = step_r + 5'd1;
      if (step_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    q_r    <= q_nxt;
    n_r    <= n_nxt;
    zero_r <= zero_nxt;
  end

  assign status.done = done_r;
  assign status.zero = zero_r;
  assign status.mean = q_r;

endmodule

`default_nettype wire

[sv/rqer_exp.sv]
// Exponent unit: 2^-(mean*log2(10)/10) by repeated root multiplies on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module rqer_exp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [31:0]     mean,
  input  wire logic            zero,
  output rqer_pkg::exp_status_t status
);
  import rqer_pkg::*;

  localparam logic [8:0]  SHIFT_BIAS = 9'(32 - ERR_FRAC_BITS);
  localparam logic [64:0] ERR_ONE    = 65'(1) << ERR_FRAC_BITS;

  exp_phase_t  phase_r, phase_nxt;
  logic [4:0]  step_r;
  logic [31:0] mean_r;
  logic        zero_r;
  logic [7:0]  i_r;
  logic [31:0] f_r;
  logic [32:0] r_r;
  logic [ERR_W-1:0] err_r;
  logic        done_r;

  logic        sel_t;
  logic        ld_t;
  logic        ld_root;
  logic        ld_round;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;

  logic [8:0]  shift;
  logic [64:0] half;
  logic [64:0] rounded;
  logic [ERR_W-1:0] err_val;

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      EX_IDLE:  if (start) phase_nxt = EX_TMUL;
      EX_TMUL:  phase_nxt = EX_ROOT;
      EX_ROOT:  if (step_r == 5'd31) phase_nxt = EX_ROUND;
      EX_ROUND: phase_nxt = EX_IDLE;
      default:  phase_nxt = EX_IDLE;
    endcase
  end

  // Phase outputs.
  always_comb begin
    sel_t    = 1'b0;
    ld_t     = 1'b0;
    ld_root  = 1'b0;
    ld_round = 1'b0;
    unique case (phase_r)
      EX_IDLE:  ;
      EX_TMUL: begin
        sel_t = 1'b1;
        ld_t  = 1'b1;
      end
      EX_ROOT:  ld_root  = 1'b1;
      EX_ROUND: ld_round = 1'b1;
      default:  ;
    endcase
  end

  // The one multiplier: first the exponent scaling, then the root products.
  always_comb begin
    mul_a = sel_t ? {1'b0, mean_r} : r_r;
    mul_b = sel_t ? LOG2_10_Q32 : ROOT_TAB[step_r];
    prod  = 65'(mul_a) * 65'(mul_b);
  end

  // Final shift by the integer part with rounding half up, then clamp at one; zero if flagged or the shift reaches 64.
  always_comb begin
    shift   = {1'b0, i_r} + SHIFT_BIAS;
    half    = (shift == 9'd0) ? 65'd0 : (65'(1) << (shift[5:0] - 6'd1));
    rounded = (65'(r_r) + half) >> shift[5:0];
    if (zero_r || (shift >= 9'd64)) begin
      err_val = '0;
    end else if (rounded > ERR_ONE) begin
      err_val = ERR_ONE[ERR_W-1:0];
    end else begin
      err_val = rounded[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= EX_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= ld_round;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      mean_r <= mean;
      zero_r <= zero;
    end
    if (ld_t) begin
      i_r    <= prod[63:56];
      f_r    <= prod[55:24];
      r_r    <= 33'h1_0000_0000;
      step_r <= '0;
    end
    if (ld_root) begin
      if (f_r[31]) begin
        r_r <= prod[64:32];
      end
      f_r    <= {f_r[30:0], 1'b0};
      step_r <= step_r + 5'd1;
    end
    if (ld_round) begin
      err_r <= err_val;
    end
  end

  assign status.done = done_r;
  assign status.err  = err_r;

endmodule

`default_nettype wire

[sv/read_quality_error_rate.sv]
// Top level: read quality statistics with a sequenced error rate computation.
// Position items: one item per cycle, no result, in_stall low while idle.
// Finish item: the result is computed in 32 divider steps, one scaling multiply, 32 root
// multiplies on the shared multiplier, rounding and handoff; the next item is taken only
// after the result has been loaded into the output register. The result waits until taken.
// Synchronous active-low reset clears all counters and sets reads_wanted to 10000.
`timescale 1ns / 1ps
`default_nettype none

module read_quality_error_rate #(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire rqer_pkg::rqer_in_t in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      rqer_pkg::rqer_out_t out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);
  import rqer_pkg::*;

  seq_state_t  state_r, state_nxt;
  logic        in_accept;
  logic        fin_accept;
  logic        div_start;
  logic        exp_start;
  logic        out_load;
  logic        out_free;

  stats_t      stats;
  div_status_t div_st;
  exp_status_t exp_st;

  rqer_out_t   pend_r;
  rqer_out_t   load_data;
  rqer_out_t   out_r;
  logic        out_valid_r;

  assign in_accept  = in_valid && !in_stall;
  assign fin_accept = in_accept && in_data.action;
  assign out_free   = !out_valid_r || !out_stall;

  rqer_stats #(
    .LEN_BITS (LEN_BITS)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_accept),
    .item       (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stats      (stats)
  );

  rqer_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .sum    (stats.quality_sum),
    .cnt    (stats.base_count),
    .status (div_st)
  );

  rqer_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .mean   (div_st.mean),
    .zero   (div_st.zero),
    .status (exp_st)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (fin_accept) state_nxt = ST_DIV;
      ST_DIV:  if (div_st.done) state_nxt = ST_EXP;
      ST_EXP:  if (exp_st.done) state_nxt = ST_LOAD;
      ST_LOAD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    exp_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = fin_accept;
      end
      ST_DIV:  exp_start = div_st.done;
      ST_EXP:  ;
      ST_LOAD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Snapshot of the counters taken with the finish item.
  always_ff @(posedge clk) begin
    if (fin_accept) begin
      pend_r.error_rate     <= '0;
      pend_r.bases_counted  <= stats.base_count;
      pend_r.unscored_reads <= stats.unscored;
      pend_r.longest_read   <= stats.longest;
      pend_r.scored_reads   <= stats.scored;
    end
  end

  // Result with the computed error rate merged in.
  always_comb begin
    load_data            = pend_r;
    load_data.error_rate = exp_st.err;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[sv/rqer_checker.sv]
// Port-level checker for the read quality error rate block and its bind.
`timescale 1ns / 1ps
`default_nettype none

module rqer_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire rqer_pkg::rqer_in_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rqer_pkg::rqer_out_t out_data
);
  import rqer_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A finish item blocks the input while the error rate is computed.
  a_fin_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.action) |=> in_stall)
    else $error("input not stalled after finish item");

  // The error rate never exceeds one.
  a_err_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_rate <= 25'h100_0000))
    else $error("error rate above one");

  // No scored bases means an error rate of zero.
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.bases_counted == 40'd0)) |-> (out_data.error_rate == 25'd0))
    else $error("error rate nonzero without bases");

endmodule

bind read_quality_error_rate rqer_checker u_rqer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
